[design/assert_macros.svh]
// assertion macros shared by the local alignment score design
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define LAS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("las assertion failed");
// implication checked in the same cycle
`define LAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("las assertion failed");
// implication checked in the cycle after the antecedent
`define LAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("las assertion failed");
`else
`define LAS_ASSERT(lbl, clk, rst_n, prop)
`define LAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/las_pkg.sv]
// types and constants of the local alignment score block
// no dependencies; used by las_cfg, las_cell and the top level
package las_pkg;

    localparam int SYM_W   = 8;
    localparam int SCORE_W = 11;
    localparam int CAND_W  = 13;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 11'd2047;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam logic [2:0] MATCH_RST    = 3'd2;
    localparam logic [3:0] MISMATCH_RST = 4'hF;
    localparam logic [3:0] GAP_RST      = 4'hF;

    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic [2:0]        match_score;
        logic signed [3:0] mismatch_score;
        logic signed [3:0] gap_score;
    } cfg_t;

    // request travelling down the cell chain
    typedef struct packed {
        logic             valid;
        logic             subject;
        logic             last;
        logic             clear;
        logic             store;
        logic             ovf;
        logic [SYM_W-1:0] symbol;
        score_t           up;
        score_t           diag;
        score_t           max;
    } token_t;

endpackage

[design/las_if.sv]
// request and result channel interfaces of the local alignment score block
// no dependencies
interface las_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output req_type, output symbol, output last, input ready);
    modport sink (input valid, input req_type, input symbol, input last, output ready);
endinterface

interface las_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] best_score;
    logic        query_overflow;

    modport source (output valid, output best_score, output query_overflow, input ready);
    modport sink (input valid, input best_score, input query_overflow, output ready);
endinterface

[design/las_cfg.sv]
// configuration registers behind the apb-style port
// depends on las_pkg
module las_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output las_pkg::cfg_t cfg
);
    import las_pkg::*;

    logic [2:0] match_reg;
    logic [3:0] mismatch_reg;
    logic [3:0] gap_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= MATCH_RST;
            mismatch_reg <= MISMATCH_RST;
            gap_reg      <= GAP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MATCH:    match_reg    <= pwdata[2:0];
                REG_MISMATCH: mismatch_reg <= pwdata[3:0];
                REG_GAP:      gap_reg      <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MATCH:    prdata = {29'd0, match_reg};
            REG_MISMATCH: prdata = {{28{mismatch_reg[3]}}, mismatch_reg};
            REG_GAP:      prdata = {{28{gap_reg[3]}}, gap_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.match_score    = match_reg;
    assign cfg.mismatch_score = mismatch_reg;
    assign cfg.gap_score      = gap_reg;

endmodule

[design/las_cell.sv]
// one cell of the systolic chain: one query symbol and its score column entry
// depends on las_pkg and assert_macros.svh
`include "assert_macros.svh"
module las_cell #(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  las_pkg::cfg_t     cfg,
    input  las_pkg::token_t   tok_i,
    input  logic [IDX_W-1:0]  idx_i,
    output las_pkg::token_t   tok_o,
    output logic [IDX_W-1:0]  idx_o
);
    import las_pkg::*;

    logic [SYM_W-1:0]         q_reg;
    logic [SYM_W-1:0]         q_next;
    logic                     loaded_reg;
    logic                     loaded_next;
    score_t                   h_reg;
    score_t                   h_next;
    token_t                   tok_o_reg;
    token_t                   tok_o_next;
    logic [IDX_W-1:0]         idx_o_reg;
    logic signed [CAND_W-1:0] w_ext;
    logic signed [CAND_W-1:0] diag_c;
    logic signed [CAND_W-1:0] up_c;
    logic signed [CAND_W-1:0] left_c;
    logic signed [CAND_W-1:0] best;
    logic signed [CAND_W-1:0] gap_ext;
    score_t                   cell_val;
    logic                     hit;
    logic                     work;

    assign hit     = tok_i.store && (idx_i == IDX_W'(CELL_IDX));
    assign work    = tok_i.valid && tok_i.subject && loaded_reg;
    assign gap_ext = {{(CAND_W-4){cfg.gap_score[3]}}, cfg.gap_score};
    assign w_ext   = (q_reg == tok_i.symbol)
                   ? $signed({{(CAND_W-3){1'b0}}, cfg.match_score})
                   : $signed({{(CAND_W-4){cfg.mismatch_score[3]}}, cfg.mismatch_score});

    always_comb
    begin
        diag_c = $signed({2'b00, tok_i.diag}) + w_ext;
        up_c   = $signed({2'b00, tok_i.up}) + gap_ext;
        left_c = $signed({2'b00, h_reg}) + gap_ext;
        best   = diag_c;
        if (up_c > best)
        begin
            best = up_c;
        end
        if (left_c > best)
        begin
            best = left_c;
        end
        // zero floor and saturation
        if (best < 0)
        begin
            cell_val = '0;
        end
        else if (best > $signed({2'b00, SCORE_MAX}))
        begin
            cell_val = SCORE_MAX;
        end
        else
        begin
            cell_val = best[SCORE_W-1:0];
        end
    end

    always_comb
    begin
        q_next      = q_reg;
        loaded_next = loaded_reg;
        h_next      = h_reg;
        tok_o_next  = tok_i;
        if (tok_i.valid && !tok_i.subject)
        begin
            if (tok_i.clear)
            begin
                h_next      = '0;
                loaded_next = 1'b0;
            end
            if (hit)
            begin
                q_next      = tok_i.symbol;
                loaded_next = 1'b1;
            end
        end
        if (work)
        begin
            // the last subject symbol leaves the column cleared
            h_next          = tok_i.last ? '0 : cell_val;
            tok_o_next.up   = cell_val;
            tok_o_next.diag = h_reg;
            tok_o_next.max  = (cell_val > tok_i.max) ? cell_val : tok_i.max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            h_reg      <= '0;
            tok_o_reg  <= '0;
            idx_o_reg  <= '0;
        end
        else if (en)
        begin
            loaded_reg <= loaded_next;
            h_reg      <= h_next;
            tok_o_reg  <= tok_o_next;
            idx_o_reg  <= idx_i;
        end
    end

    assign tok_o = tok_o_reg;
    assign idx_o = idx_o_reg;

    `LAS_ASSERT_NOW(a_unloaded_zero, clk, rst_n, !loaded_reg, h_reg == '0)
    `LAS_ASSERT_NEXT(a_last_clears, clk, rst_n, en && tok_i.valid && tok_i.subject && tok_i.last, h_reg == '0)
    `LAS_ASSERT_NEXT(a_max_grows, clk, rst_n, en && tok_i.valid, tok_o_reg.max >= $past(tok_i.max))

endmodule

[design/local_alignment_score_unit.sv]
// top level of the local alignment score block: head control, cell chain, result stage
// depends on las_pkg, las_if, las_cfg, las_cell and assert_macros.svh
//
// usage: req carries query loads (req_type 0) and subject symbols (req_type 1),
// each with a last flag. load the query first, then stream the subject; the
// subject symbol marked last yields one result on rsp: the best local
// alignment score (saturating at 2047) and whether query symbols were dropped.
// a query load after a closed query starts a new query.
// every request walks a chain of MAX_QUERY_LEN cells, one cell per cycle unless
// the chain is held; each cell holds one query symbol and its column score, so a
// request may be sent in every cycle and the sustained rate is one request per
// cycle while the chain runs. an accepted last subject symbol passes the head
// register, the MAX_QUERY_LEN cell registers and the output register to rsp.valid.
// reset clears all scores, the query length and the flags and restores the
// register defaults; no clearing pass is needed, requests are taken at once.
// a result waits in the output register while the chain keeps running; only
// when a second result reaches the chain end before the first is taken does
// the whole chain, and req.ready, hold until rsp.ready.
// registers: match at 0x0, mismatch at 0x4, gap at 0x8 (write only while idle)
`include "assert_macros.svh"
module local_alignment_score_unit #(
    parameter int MAX_QUERY_LEN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    las_req_if.sink     req,
    las_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import las_pkg::*;

    localparam int LEN_W = $clog2(MAX_QUERY_LEN + 1);
    localparam int IDX_W = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;

    cfg_t             cfg;
    token_t           tok [0:MAX_QUERY_LEN];
    logic [IDX_W-1:0] idx [0:MAX_QUERY_LEN];

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             closed_reg;
    logic             closed_next;
    token_t           head_reg;
    token_t           head_next;
    logic [IDX_W-1:0] head_idx_reg;
    logic [IDX_W-1:0] head_idx_next;
    score_t           rmax_reg;
    score_t           rmax_next;
    score_t           tail_max;
    logic             out_valid_reg;
    score_t           out_score_reg;
    logic             out_ovf_reg;
    logic [LEN_W-1:0] len_eff;
    logic             en;
    logic             acc;
    logic             tail_result;

    las_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the chain holds only when a finished result cannot leave the end
    assign tail_result = tok[MAX_QUERY_LEN].valid && tok[MAX_QUERY_LEN].subject
                       && tok[MAX_QUERY_LEN].last;
    assign en          = !(tail_result && out_valid_reg && !rsp.ready);
    assign req.ready   = en;
    assign acc         = req.valid && en;

    // head control: query bookkeeping at the accepting edge
    always_comb
    begin
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        closed_next   = closed_reg;
        head_next     = '0;
        head_idx_next = '0;
        len_eff       = closed_reg ? '0 : len_reg;
        if (acc)
        begin
            head_next.valid   = 1'b1;
            head_next.subject = req.req_type;
            head_next.last    = req.last;
            head_next.symbol  = req.symbol;
            if (!req.req_type)
            begin
                head_next.clear = closed_reg;
                len_next        = len_eff;
                if (closed_reg)
                begin
                    ovf_next = 1'b0;
                end
                closed_next = req.last;
                if (len_eff < LEN_W'(MAX_QUERY_LEN))
                begin
                    head_next.store = 1'b1;
                    head_idx_next   = len_eff[IDX_W-1:0];
                    len_next        = len_eff + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                head_next.ovf = ovf_next;
            end
            else
            begin
                closed_next   = 1'b1;
                head_next.ovf = ovf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            closed_reg   <= 1'b0;
            head_reg     <= '0;
            head_idx_reg <= '0;
        end
        else if (en)
        begin
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            closed_reg   <= closed_next;
            head_reg     <= head_next;
            head_idx_reg <= head_idx_next;
        end
    end

    assign tok[0] = head_reg;
    assign idx[0] = head_idx_reg;

    for (genvar i = 0; i < MAX_QUERY_LEN; i++)
    begin : g_cell
        las_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cfg   (cfg),
            .tok_i (tok[i]),
            .idx_i (idx[i]),
            .tok_o (tok[i+1]),
            .idx_o (idx[i+1])
        );
    end

    // result stage: running maximum over subject columns
    assign tail_max = (tok[MAX_QUERY_LEN].max > rmax_reg) ? tok[MAX_QUERY_LEN].max : rmax_reg;

    always_comb
    begin
        rmax_next = rmax_reg;
        if (tok[MAX_QUERY_LEN].valid)
        begin
            if (tok[MAX_QUERY_LEN].subject)
            begin
                rmax_next = tok[MAX_QUERY_LEN].last ? '0 : tail_max;
            end
            else if (tok[MAX_QUERY_LEN].clear)
            begin
                rmax_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmax_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                rmax_reg <= rmax_next;
            end
            if (en && tail_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tail_result)
        begin
            out_score_reg <= tail_max;
            out_ovf_reg   <= tok[MAX_QUERY_LEN].ovf;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.best_score     = out_score_reg;
    assign rsp.query_overflow = out_ovf_reg;

    `LAS_ASSERT_NOW(a_stall_pending, clk, rst_n, !en, out_valid_reg)
    `LAS_ASSERT_NOW(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(en && tail_result))
    `LAS_ASSERT_NEXT(a_max_cleared, clk, rst_n, en && tail_result, rmax_reg == '0)
    `LAS_ASSERT(a_len_range, clk, rst_n, len_reg <= LEN_W'(MAX_QUERY_LEN))

endmodule

[tb/sv/local_alignment_score_unit_test.sv]
// self-checking testbench of local_alignment_score_unit: directed and random request
// traffic with a scoring predictor of its own; depends on las_pkg, las_if and the design
module local_alignment_score_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import las_pkg::*;

    localparam int CHAIN_LEN      = 256;
    localparam int SETTLE_CYCLES  = CHAIN_LEN + 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 120;

    localparam bit REQ_QUERY   = 1'b0;
    localparam bit REQ_SUBJECT = 1'b1;

    localparam logic [3:0] ADDR_MATCH    = {REG_MATCH, 2'b00};
    localparam logic [3:0] ADDR_MISMATCH = {REG_MISMATCH, 2'b00};
    localparam logic [3:0] ADDR_GAP      = {REG_GAP, 2'b00};
    localparam logic [3:0] ADDR_UNUSED   = 4'hC;

    typedef struct {
        logic [SCORE_W-1:0] best;
        logic               ovf;
    } score_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    las_req_if req_ch ();
    las_rsp_if rsp_ch ();

    local_alignment_score_unit #(
        .MAX_QUERY_LEN(CHAIN_LEN)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .rsp    (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // scoring state mirrored from the block
    logic [2:0]        cfg_match;
    logic signed [3:0] cfg_mismatch;
    logic signed [3:0] cfg_gap;
    logic [7:0]        query_sym [CHAIN_LEN];
    int                query_len;
    logic [10:0]       score_col [CHAIN_LEN];
    logic [10:0]       running_best;
    bit                query_ovf;
    bit                query_closed;

    score_result_t expected_scores[$];

    int idle_pct;
    int stall_pct;
    int rsp_hold_left;
    int stuck_cycles;
    int requests_sent;
    int scores_checked;
    int settings_used;
    int fail_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] pick_symbol(bit wide);
        logic [7:0] bases [4];
        bases = '{8'h41, 8'h43, 8'h47, 8'h54};
        if (wide)
            return 8'($urandom_range(255));
        return bases[$urandom_range(3)];
    endfunction

    function automatic void clear_scores();
        for (int i = 0; i < CHAIN_LEN; i++)
            score_col[i] = '0;
        running_best = '0;
    endfunction

    function automatic void advance_alignment(bit rt, logic [7:0] sym, bit last);
        int mat;
        int mis;
        int gap;
        int diag;
        int up;
        int left;
        int best;
        int cell_score;
        score_result_t r;
        if (rt == REQ_QUERY)
        begin
            if (query_closed)
            begin
                query_len = 0;
                query_ovf = 1'b0;
                query_closed = 1'b0;
                clear_scores();
            end
            if (query_len < CHAIN_LEN)
            begin
                query_sym[query_len] = sym;
                query_len++;
            end
            else
                query_ovf = 1'b1;
            if (last)
                query_closed = 1'b1;
            return;
        end
        query_closed = 1'b1;
        mat = cfg_match;
        mis = cfg_mismatch;
        gap = cfg_gap;
        diag = 0;
        up = 0;
        for (int i = 0; i < query_len; i++)
        begin
            left = score_col[i];
            best = diag + ((query_sym[i] == sym) ? mat : mis);
            if (up + gap > best)
                best = up + gap;
            if (left + gap > best)
                best = left + gap;
            cell_score = (best < 0) ? 0 : (best > 2047) ? 2047 : best;
            score_col[i] = 11'(cell_score);
            if (11'(cell_score) > running_best)
                running_best = 11'(cell_score);
            diag = left;
            up = cell_score;
        end
        if (!last)
            return;
        r.best = running_best;
        r.ovf = query_ovf;
        expected_scores = {expected_scores, r};
        clear_scores();
    endfunction

    task automatic send_request(bit rt, logic [7:0] sym, bit last);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.symbol <= sym;
        req_ch.last <= last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        advance_alignment(rt, sym, last);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        // requests with no result may still be walking the chain
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(logic [3:0] addr, logic [31:0] mask, logic [31:0] want);
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) != (want & mask))
        begin
            $display("%0t register 0x%0h: expected 0x%0h, actual 0x%0h",
                     $time, addr, want & mask, got & mask);
            fail_count++;
        end
    endtask

    // upper data bits carry junk, the block keeps only the register width
    task automatic program_scoring(int m, int mis, int gap);
        logic [31:0] junk;
        junk = $urandom;
        apb_write(ADDR_MATCH, {junk[31:3], 3'(m)});
        apb_write(ADDR_MISMATCH, {junk[31:4], 4'(mis)});
        apb_write(ADDR_GAP, {junk[31:4], 4'(gap)});
        cfg_match = 3'(m);
        cfg_mismatch = 4'(mis);
        cfg_gap = 4'(gap);
        apb_read_check(ADDR_MATCH, 32'h7, {29'b0, cfg_match});
        apb_read_check(ADDR_MISMATCH, 32'hF, {28'b0, cfg_mismatch});
        apb_read_check(ADDR_GAP, 32'hF, {28'b0, cfg_gap});
        settings_used++;
    endtask

    task automatic send_string(bit rt, logic [7:0] syms [$]);
        foreach (syms[i])
            send_request(rt, syms[i], i == syms.size() - 1);
    endtask

    // subject right after reset: no query symbols, so the score is zero
    task automatic test_empty_query();
        send_request(REQ_SUBJECT, 8'hFF, 1'b1);
        drain_results();
    endtask

    task automatic test_basic_alignment();
        send_string(REQ_QUERY, '{8'h00, 8'hFF, 8'h41, 8'h41});
        send_string(REQ_SUBJECT, '{8'hFF, 8'h41, 8'h41});
        // query left open: the subject closes it and the next load starts over
        send_request(REQ_QUERY, 8'h41, 1'b0);
        send_request(REQ_QUERY, 8'h42, 1'b0);
        send_request(REQ_SUBJECT, 8'h41, 1'b1);
        send_request(REQ_QUERY, 8'h42, 1'b1);
        send_string(REQ_SUBJECT, '{8'h42, 8'h80});
        drain_results();
    endtask

    task automatic test_register_extremes();
        program_scoring(7, -8, -8);
        // a write past the register list must change nothing
        apb_write(ADDR_UNUSED, $urandom);
        apb_read_check(ADDR_MATCH, 32'h7, {29'b0, cfg_match});
        send_string(REQ_QUERY, '{8'h41, 8'h41, 8'h42});
        send_string(REQ_SUBJECT, '{8'h41, 8'h41, 8'h42});
        drain_results();
        program_scoring(0, 0, 0);
        send_string(REQ_QUERY, '{8'h00, 8'hFF});
        send_string(REQ_SUBJECT, '{8'hFF, 8'h00});
        drain_results();
        program_scoring(3, 0, -8);
        send_string(REQ_QUERY, '{8'h7F, 8'h01});
        send_string(REQ_SUBJECT, '{8'h01, 8'h7F});
        drain_results();
    endtask

    // full query plus dropped symbols, the last one dropped too, then the top score
    // reachable at this capacity (7 per matching step, 1792, below saturation)
    task automatic test_query_full();
        program_scoring(7, -8, -8);
        for (int i = 0; i < CHAIN_LEN + 2; i++)
            send_request(REQ_QUERY, 8'h41, i == CHAIN_LEN + 1);
        for (int i = 0; i < CHAIN_LEN; i++)
            send_request(REQ_SUBJECT, 8'h41, i == CHAIN_LEN - 1);
        // a new query clears the overflow flag
        send_string(REQ_QUERY, '{8'h41, 8'h43, 8'h47});
        send_string(REQ_SUBJECT, '{8'h43, 8'h47});
        drain_results();
    endtask

    task automatic test_output_pressure();
        program_scoring(2, -1, -1);
        rsp_hold_left = 1000;
        send_string(REQ_QUERY, '{8'h41, 8'h43});
        for (int i = 0; i < 300; i++)
            send_request(REQ_SUBJECT, pick_symbol(1'b0), i % 5 == 4);
        drain_results();
    endtask

    task automatic random_job();
        int kind;
        int qlen;
        int slen;
        bit wide;
        kind = $urandom_range(39);
        wide = ($urandom_range(4) == 0);
        if (kind < 28)
        begin
            qlen = (kind == 0) ? $urandom_range(200, 265) : $urandom_range(1, 12);
            for (int i = 0; i < qlen; i++)
                send_request(REQ_QUERY, pick_symbol(wide), i == qlen - 1);
            slen = $urandom_range(1, 16);
            for (int i = 0; i < slen; i++)
                send_request(REQ_SUBJECT, pick_symbol(wide), i == slen - 1);
        end
        else if (kind < 34)
        begin
            // another subject against the query already held
            slen = $urandom_range(1, 12);
            for (int i = 0; i < slen; i++)
                send_request(REQ_SUBJECT, pick_symbol(wide), i == slen - 1);
        end
        else if (kind < 38)
        begin
            qlen = $urandom_range(1, 6);
            for (int i = 0; i < qlen; i++)
                send_request(REQ_QUERY, pick_symbol(wide), 1'b0);
            slen = $urandom_range(1, 8);
            for (int i = 0; i < slen; i++)
                send_request(REQ_SUBJECT, pick_symbol(wide), i == slen - 1);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_request(1'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int idle_mode [4];
        int stall_mode [4];
        int start;
        idle_mode = '{0, 73, 0, 36};
        stall_mode = '{0, 0, 73, 36};
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: program_scoring(MATCH_RST, $signed(MISMATCH_RST), $signed(GAP_RST));
                1: program_scoring(7, 0, -8);
                default: program_scoring($urandom_range(7), -$urandom_range(8),
                                         -$urandom_range(8));
            endcase
            idle_pct = idle_mode[p];
            stall_pct = stall_mode[p];
            start = requests_sent;
            while (requests_sent - start < PHASE_ITEMS)
                random_job();
            drain_results();
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // result ready, with the long hold-off counted here
    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left = rsp_hold_left - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_scores
        score_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_scores.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual best_score %0d overflow %0b",
                         $time, rsp_ch.best_score, rsp_ch.query_overflow);
                fail_count++;
            end
            else
            begin
                want = expected_scores.pop_front();
                if (rsp_ch.best_score !== want.best)
                begin
                    $display("%0t best_score: expected %0d, actual %0d",
                             $time, want.best, rsp_ch.best_score);
                    fail_count++;
                end
                if (rsp_ch.query_overflow !== want.ovf)
                begin
                    $display("%0t query_overflow: expected %0b, actual %0b",
                             $time, want.ovf, rsp_ch.query_overflow);
                    fail_count++;
                end
                scores_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("local_alignment_score_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_QUERY;
        req_ch.symbol = '0;
        req_ch.last = 1'b0;
        rsp_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        rsp_hold_left = 0;
        stuck_cycles = 0;
        requests_sent = 0;
        scores_checked = 0;
        settings_used = 1;
        fail_count = 0;
        cfg_match = MATCH_RST;
        cfg_mismatch = MISMATCH_RST;
        cfg_gap = GAP_RST;
        query_len = 0;
        query_ovf = 1'b0;
        query_closed = 1'b0;
        for (int i = 0; i < CHAIN_LEN; i++)
            query_sym[i] = '0;
        clear_scores();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_query();
        test_basic_alignment();
        test_register_extremes();
        test_query_full();
        test_output_pressure();
        test_random_traffic();

        $display("covered %0d requests and %0d checked scores over %0d scoring settings,",
                 requests_sent, scores_checked, settings_used);
        $display("with a full query, a long result hold-off and four pacing modes");
        if (fail_count == 0 && expected_scores.size() == 0)
            $display("local_alignment_score_unit regression: pass");
        else
            $display("local_alignment_score_unit regression: fail");
        $finish;
    end

endmodule
